// ----- sv/lsif_pkg.sv -----
package lsif_pkg;

    localparam int COORD_BITS_DEF = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SETUP,
        ST_GCD_START,
        ST_GCD_WAIT,
        ST_DIVN_START,
        ST_DIVN_WAIT,
        ST_DIVD_START,
        ST_DIVD_WAIT,
        ST_NEXT,
        ST_OUT
    } t_state;

endpackage

// ----- sv/lsif_div.sv -----
// Restoring divider, one quotient bit per cycle.
module lsif_div import lsif_pkg::*; #(
    parameter int W = 34
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [W:0]    w_sh;
    logic [W:0]    w_diff;

    always_comb begin
        w_sh   = {r_rem, r_quo[W-1]};
        w_diff = w_sh - {1'b0, r_den};
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_cnt  = CW'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_diff[W]) begin
                n_rem = w_sh[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b0};
            end else begin
                n_rem = w_diff[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b1};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

// ----- sv/lsif_seq.sv -----
// Sequencer: gcd by repeated remainder, then two quotients, for slope then intercept.
module lsif_seq import lsif_pkg::*; #(
    parameter int W = 34
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_go,
    input  logic         i_mul_ok,
    input  logic [W-1:0] i_sl_num,
    input  logic [W-1:0] i_sl_den,
    input  logic         i_sl_neg,
    input  logic [W-1:0] i_ic_num,
    input  logic [W-1:0] i_ic_den,
    input  logic         i_ic_neg,
    input  logic         i_out_stall,
    output logic         o_busy,
    output logic         o_mul,
    output logic         o_valid,
    output logic [W-1:0] o_sl_nm,
    output logic [W-1:0] o_sl_dm,
    output logic         o_sl_neg,
    output logic [W-1:0] o_ic_nm,
    output logic [W-1:0] o_ic_dm,
    output logic         o_ic_neg
);
    t_state       r_st, n_st;
    logic         r_sel;
    logic [W-1:0] r_a, r_b, r_g, r_nm;
    logic         r_neg;
    logic         w_start;
    logic [W-1:0] w_dn, w_dd, w_q, w_r;
    logic         w_done;

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:       if (i_go) n_st = ST_MUL;
            ST_MUL:        if (i_mul_ok) n_st = ST_SETUP;
            ST_SETUP:      n_st = ST_GCD_START;
            ST_GCD_START:  n_st = (r_a == '0) ? ST_NEXT :
                                  (r_b == '0) ? ST_DIVN_START : ST_GCD_WAIT;
            ST_GCD_WAIT:   if (w_done) n_st = ST_GCD_START;
            ST_DIVN_START: n_st = ST_DIVN_WAIT;
            ST_DIVN_WAIT:  if (w_done) n_st = ST_DIVD_START;
            ST_DIVD_START: n_st = ST_DIVD_WAIT;
            ST_DIVD_WAIT:  if (w_done) n_st = ST_NEXT;
            ST_NEXT:       n_st = r_sel ? ST_OUT : ST_SETUP;
            ST_OUT:        if (!i_out_stall) n_st = ST_IDLE;
            default:       n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        w_start = 1'b0;
        w_dn    = r_a;
        w_dd    = r_b;
        case (r_st)
            ST_GCD_START:  w_start = (r_a != '0) && (r_b != '0);
            ST_DIVN_START: begin
                w_start = 1'b1;
                w_dn    = r_sel ? i_ic_num : i_sl_num;
                w_dd    = r_g;
            end
            ST_DIVD_START: begin
                w_start = 1'b1;
                w_dn    = r_sel ? i_ic_den : i_sl_den;
                w_dd    = r_g;
            end
            default: ;
        endcase
    end

    lsif_div #(.W(W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(w_dn), .i_den(w_dd), .o_done(w_done), .o_quo(w_q), .o_rem(w_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_sel <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_IDLE) r_sel <= 1'b0;
            if (r_st == ST_NEXT) r_sel <= 1'b1;
        end
        case (r_st)
            ST_SETUP: begin
                r_a   <= r_sel ? i_ic_num : i_sl_num;
                r_b   <= r_sel ? i_ic_den : i_sl_den;
                r_neg <= r_sel ? i_ic_neg : i_sl_neg;
            end
            ST_GCD_START: if (r_b == '0) r_g <= r_a;
            ST_GCD_WAIT: if (w_done) begin
                r_a <= r_b;
                r_b <= w_r;
            end
            ST_DIVN_WAIT: if (w_done) r_nm <= w_q;
            ST_DIVD_WAIT: if (w_done) begin
                if (r_sel) begin
                    o_ic_nm <= r_nm; o_ic_dm <= w_q; o_ic_neg <= r_neg;
                end else begin
                    o_sl_nm <= r_nm; o_sl_dm <= w_q; o_sl_neg <= r_neg;
                end
            end
            default: ;
        endcase
        // zero numerator: 0/1, positive
        if (r_st == ST_GCD_START && r_a == '0) begin
            if (r_sel) begin
                o_ic_nm <= '0; o_ic_dm <= W'(1); o_ic_neg <= 1'b0;
            end else begin
                o_sl_nm <= '0; o_sl_dm <= W'(1); o_sl_neg <= 1'b0;
            end
        end
    end

    assign o_busy  = (r_st != ST_IDLE);
    assign o_mul   = (r_st == ST_MUL);
    assign o_valid = (r_st == ST_OUT);
endmodule

// ----- sv/line_slope_intercept_fraction_core.sv -----
// Two-point line equation. Accepts (x1,y1),(x2,y2) and presents the slope
// and intercept as reduced fractions (magnitudes plus sign). Vertical lines
// (x1 == x2) give no result.
// One word at a time: a shared restoring divider performs each Euclid remainder
// step and the two reductions per fraction; stall is high from accept until the
// result word is taken.
// No reset clearing pass.
module line_slope_intercept_fraction_core import lsif_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [COORD_BITS-1:0] i_first_x,
    input  logic [COORD_BITS-1:0] i_first_y,
    input  logic [COORD_BITS-1:0] i_second_x,
    input  logic [COORD_BITS-1:0] i_second_y,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [15:0]           o_slope_num_mag,
    output logic [15:0]           o_slope_den_mag,
    output logic                  o_slope_negative,
    output logic [31:0]           o_icpt_num_mag,
    output logic [15:0]           o_icpt_den_mag,
    output logic                  o_icpt_negative
);
    localparam int CB = COORD_BITS;
    localparam int W  = 2 * CB + 2;

    logic signed [CB-1:0] r_x1, r_y1, r_x2, r_y2;
    logic signed [W-1:0]  r_p1, r_p2;
    logic                 r_mul_ok;
    logic [W-1:0]         w_sl_num, w_sl_den, w_ic_num, w_ic_den;
    logic                 w_sl_neg, w_ic_neg;
    logic signed [W-1:0]  w_dy, w_dx, w_in;
    logic                 w_busy, w_mul, w_go, w_valid;
    logic [W-1:0]         w_sl_nm, w_sl_dm, w_ic_nm, w_ic_dm;
    logic                 w_sl_ng, w_ic_ng;

    assign w_go    = i_valid && !w_busy && (i_first_x != i_second_x);
    assign o_stall = w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_ok <= 1'b0;
        end else begin
            r_mul_ok <= w_mul && !r_mul_ok;
        end
        if (i_valid && !w_busy) begin
            r_x1 <= i_first_x; r_y1 <= i_first_y;
            r_x2 <= i_second_x; r_y2 <= i_second_y;
        end
        // products, registered while the sequencer is in its multiply state
        if (w_mul) begin
            r_p1 <= W'(r_x2 * r_y1);
            r_p2 <= W'(r_x1 * r_y2);
        end
    end

    assign w_dy = W'(r_y1) - W'(r_y2);
    assign w_dx = W'(r_x1) - W'(r_x2);
    assign w_in = r_p1 - r_p2;
    assign w_sl_num = w_dy[W-1] ? W'(-w_dy) : w_dy;
    assign w_sl_den = w_dx[W-1] ? W'(-w_dx) : w_dx;
    assign w_sl_neg = w_dy[W-1] ^ w_dx[W-1];
    assign w_ic_num = w_in[W-1] ? W'(-w_in) : w_in;
    assign w_ic_den = w_sl_den;
    // intercept denominator is -dx
    assign w_ic_neg = w_in[W-1] ^ ~w_dx[W-1];

    lsif_seq #(.W(W)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(w_go), .i_mul_ok(r_mul_ok),
        .i_sl_num(w_sl_num), .i_sl_den(w_sl_den), .i_sl_neg(w_sl_neg),
        .i_ic_num(w_ic_num), .i_ic_den(w_ic_den), .i_ic_neg(w_ic_neg),
        .i_out_stall(i_stall), .o_busy(w_busy), .o_mul(w_mul), .o_valid(w_valid),
        .o_sl_nm(w_sl_nm), .o_sl_dm(w_sl_dm), .o_sl_neg(w_sl_ng),
        .o_ic_nm(w_ic_nm), .o_ic_dm(w_ic_dm), .o_ic_neg(w_ic_ng)
    );

    assign o_valid          = w_valid;
    assign o_slope_num_mag  = 16'(w_sl_nm);
    assign o_slope_den_mag  = 16'(w_sl_dm);
    assign o_slope_negative = w_sl_ng;
    assign o_icpt_num_mag   = 32'(w_ic_nm);
    assign o_icpt_den_mag   = 16'(w_ic_dm);
    assign o_icpt_negative  = w_ic_ng;

    a_den_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_slope_den_mag != 16'd0 || CB > 16))
        else $error("zero slope denominator");
    a_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_slope_num_mag == 16'd0 && CB <= 16) |-> !o_slope_negative)
        else $error("negative zero slope");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result outside busy window");
endmodule

// ----- test/line_slope_intercept_fraction_core_test.sv -----
`timescale 1ns / 1ps

module line_slope_intercept_fraction_core_test;
    import lsif_pkg::*;

    localparam int CB = COORD_BITS_DEF;

    typedef struct packed {
        logic [15:0] slope_num;
        logic [15:0] slope_den;
        logic        slope_neg;
        logic [31:0] icpt_num;
        logic [15:0] icpt_den;
        logic        icpt_neg;
    } t_line_coef;

    class line_scoreboard;
        t_line_coef pending[$];
        int errors;

        function automatic longint unsigned euclid(longint unsigned a, longint unsigned b);
            longint unsigned r;
            while (b != 0) begin
                r = a % b;
                a = b;
                b = r;
            end
            return a;
        endfunction

        function automatic void reduce_frac(longint num, longint den, output longint unsigned nm,
                                            output longint unsigned dm, output logic neg);
            longint unsigned a, b, g;
            a = num < 0 ? -num : num;
            b = den < 0 ? -den : den;
            if (a == 0) begin
                nm = 0;
                dm = 1;
                neg = 1'b0;
            end else begin
                g = euclid(a, b);
                if (g == 0) g = 1;
                nm = a / g;
                dm = b / g;
                neg = (num < 0) != (den < 0);
            end
        endfunction

        function void note_points(logic signed [CB-1:0] x1, logic signed [CB-1:0] y1,
                                  logic signed [CB-1:0] x2, logic signed [CB-1:0] y2);
            longint ax1, ay1, ax2, ay2;
            longint unsigned nm, dm;
            logic neg;
            t_line_coef c;
            ax1 = x1; ay1 = y1; ax2 = x2; ay2 = y2;
            if (ax1 == ax2) return;   // vertical line: no word out
            reduce_frac(ay1 - ay2, ax1 - ax2, nm, dm, neg);
            c.slope_num = nm[15:0];
            c.slope_den = dm[15:0];
            c.slope_neg = neg;
            reduce_frac(ax2 * ay1 - ax1 * ay2, ax2 - ax1, nm, dm, neg);
            c.icpt_num = nm[31:0];
            c.icpt_den = dm[15:0];
            c.icpt_neg = neg;
            pending.push_back(c);
        endfunction

        function void check_coef(t_line_coef got);
            t_line_coef e;
            if (pending.size() == 0) begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.slope_num !== e.slope_num) begin
                $error("slope_num_mag exp %0d got %0d", e.slope_num, got.slope_num); errors++;
            end
            if (got.slope_den !== e.slope_den) begin
                $error("slope_den_mag exp %0d got %0d", e.slope_den, got.slope_den); errors++;
            end
            if (got.slope_neg !== e.slope_neg) begin
                $error("slope_negative exp %0d got %0d", e.slope_neg, got.slope_neg); errors++;
            end
            if (got.icpt_num !== e.icpt_num) begin
                $error("icpt_num_mag exp %0d got %0d", e.icpt_num, got.icpt_num); errors++;
            end
            if (got.icpt_den !== e.icpt_den) begin
                $error("icpt_den_mag exp %0d got %0d", e.icpt_den, got.icpt_den); errors++;
            end
            if (got.icpt_neg !== e.icpt_neg) begin
                $error("icpt_negative exp %0d got %0d", e.icpt_neg, got.icpt_neg); errors++;
            end
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    logic [CB-1:0] i_first_x = '0, i_first_y = '0, i_second_x = '0, i_second_y = '0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    logic [15:0]   o_slope_num_mag, o_slope_den_mag, o_icpt_den_mag;
    logic [31:0]   o_icpt_num_mag;
    logic          o_slope_negative, o_icpt_negative;

    line_scoreboard sb;
    bit stall_random = 1'b1;

    line_slope_intercept_fraction_core i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver stall pattern: runs of stall/no-stall, some long free stretches
    always @(posedge i_clk) begin
        if (stall_random && $urandom_range(0, 9) < 3)
            i_stall <= $urandom_range(0, 1);
        else if (!stall_random)
            i_stall <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_coef({o_slope_num_mag, o_slope_den_mag, o_slope_negative,
                           o_icpt_num_mag, o_icpt_den_mag, o_icpt_negative});
    end

    task automatic send_points(logic [CB-1:0] x1, logic [CB-1:0] y1,
                               logic [CB-1:0] x2, logic [CB-1:0] y2);
        i_valid <= 1'b1;
        i_first_x <= x1; i_first_y <= y1; i_second_x <= x2; i_second_y <= y2;
        do @(posedge i_clk); while (o_stall);
        sb.note_points(x1, y1, x2, y2);
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [CB-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(CB-1){1'b0}}};
            1: return {1'b0, {(CB-1){1'b1}}};
            2: return CB'($urandom_range(0, 15)) - CB'(8);
            default: return CB'($urandom);
        endcase
    endfunction

    task automatic drain();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    localparam logic [CB-1:0] MINV = {1'b1, {(CB-1){1'b0}}};
    localparam logic [CB-1:0] MAXV = {1'b0, {(CB-1){1'b1}}};

    initial begin
        logic [CB-1:0] x1, x2;
        int burst;
        int i;
        bit drained;
        sb = new();
        drained = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, vertical, zero numerators, signs
        send_points(MINV, MINV, MAXV, MAXV);
        send_points(MAXV, MINV, MINV, MAXV);
        send_points(MINV, MAXV, MAXV, MINV);
        send_points(MAXV, MAXV, MINV, MINV);
        send_points(5, 7, 5, 9);                      // vertical
        send_points(MINV, 0, MINV, 3);                // vertical at extreme
        send_points(1, 4, 3, 4);                      // horizontal
        send_points(0, 0, 2, 6);                      // through origin
        send_points(2, 2, 4, 4);                      // zero intercept
        send_points(-CB'(3), 1, 2, -CB'(4));
        send_points(0, MINV, 1, MAXV);
        send_points(MAXV, MAXV, MAXV - CB'(1), MINV);
        send_points(-CB'(1), -CB'(1), 1, 1);
        send_points(6, 9, -CB'(4), 3);
        send_points('1, '1, 0, 0);
        send_points(MINV, MAXV, 0, 0);
        drain();

        // random bursts; midway the sender waits for all results, then the
        // receiver runs free for a stretch
        i = 0;
        while (i < 1600) begin
            burst = $urandom_range(1, 12);
            if (!drained && i >= 800) begin
                drain();
                stall_random = 1'b0;
                drained = 1'b1;
            end
            if (drained && !stall_random && i >= 1100) stall_random = 1'b1;
            for (int j = 0; j < burst && i < 1600; j++, i++) begin
                x1 = rand_coord();
                x2 = ($urandom_range(0, 19) == 0) ? x1 : rand_coord();
                send_points(x1, rand_coord(), x2, rand_coord());
            end
            idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40));
        end
        drain();
        repeat (400) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS line_slope_intercept_fraction_core");
        else
            $display("FAIL line_slope_intercept_fraction_core");
        $finish;
    end

    initial begin
        #200ms;
        $display("FAIL line_slope_intercept_fraction_core");
        $finish;
    end
endmodule

// ----- line_slope_intercept_fraction_core.f -----
sv/lsif_pkg.sv
sv/lsif_div.sv
sv/lsif_seq.sv
sv/line_slope_intercept_fraction_core.sv
test/line_slope_intercept_fraction_core_test.sv
